/* design/assert_macros.svh */
// assertion helpers used by the queue core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes for the double-ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // default ring size
  localparam int unsigned DEPTH_DEFAULT = 8;

  // request codes
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // request beat
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } req_t;

  // response beat
  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic [3:0]         occupancy;
  } rsp_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic load;    // capture the response register
  } cmd_t;

endpackage

`default_nettype wire

/* design/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// sequencer for request intake, response load and output handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output deq_pkg::cmd_t      cmd
);

  deq_pkg::state_t state;
  deq_pkg::state_t state_next;
  logic            out_full;
  logic            out_full_next;
  logic            take;

  // intake is open in idle unless a held response stays blocked
  assign take = (state == deq_pkg::S_IDLE) && !(out_full && rsp_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::S_IDLE: begin
        if (req_valid && take) state_next = deq_pkg::S_LOAD;
      end
      deq_pkg::S_LOAD: begin
        state_next = deq_pkg::S_IDLE;
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_stall     = !take;
    cmd.accept    = req_valid && take;
    cmd.load      = 1'b0;
    out_full_next = out_full && rsp_stall;
    case (state)
      deq_pkg::S_IDLE: begin
        cmd.load = 1'b0;
      end
      deq_pkg::S_LOAD: begin
        cmd.load      = 1'b1;
        out_full_next = 1'b1;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  assign rsp_valid = out_full;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= deq_pkg::S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

`default_nettype wire

/* design/deq_dp.sv */
// ----------------------------------------------------------------------------
// deq_dp
// ring store, front and back pointers, entry count and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire deq_pkg::cmd_t cmd,
  input  wire deq_pkg::req_t req,
  output deq_pkg::rsp_t      rsp
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [31:0]     mem [DEPTH];
  logic [31:0]     rd_data;

  logic [IdxW-1:0] front;
  logic [IdxW-1:0] back;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] front_next;
  logic [IdxW-1:0] back_next;
  logic [CntW-1:0] count_next;

  logic [IdxW-1:0] front_inc;
  logic [IdxW-1:0] front_dec;
  logic [IdxW-1:0] back_inc;
  logic [IdxW-1:0] back_dec;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [1:0]      status_next;
  logic [1:0]      status;
  logic            pop_ok_next;
  logic            pop_ok;

  // ring steps in both directions
  assign front_inc = (front == LastIdx) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LastIdx : front - 1'b1;
  assign back_inc  = (back == LastIdx) ? '0 : back + 1'b1;
  assign back_dec  = (back == '0) ? LastIdx : back - 1'b1;

  // request decode
  always_comb begin
    front_next  = front;
    back_next   = back;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = back;
    rd_en       = 1'b0;
    rd_addr     = front;
    status_next = deq_pkg::ST_DONE;
    pop_ok_next = 1'b0;
    case (req.req_type)
      deq_pkg::REQ_PUSH_FRONT: begin
        if (count == FullCnt) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          front_next = front_dec;
          wr_en      = 1'b1;
          wr_addr    = front_dec;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::REQ_PUSH_BACK: begin
        if (count == FullCnt) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          back_next  = back_inc;
          wr_en      = 1'b1;
          wr_addr    = back;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::REQ_POP_FRONT: begin
        if (count == '0) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          front_next  = front_inc;
          rd_en       = 1'b1;
          rd_addr     = front;
          pop_ok_next = 1'b1;
          count_next  = count - 1'b1;
        end
      end
      deq_pkg::REQ_POP_BACK: begin
        if (count == '0) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          back_next   = back_dec;
          rd_en       = 1'b1;
          rd_addr     = back_dec;
          pop_ok_next = 1'b1;
          count_next  = count - 1'b1;
        end
      end
      default: begin
        status_next = deq_pkg::ST_DONE;
      end
    endcase
  end

  // ring store with registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) mem[wr_addr] <= 32'(req.push_value);
    if (cmd.accept && rd_en) rd_data <= mem[rd_addr];
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      front  <= '0;
      back   <= '0;
      count  <= '0;
      pop_ok <= 1'b0;
    end else if (cmd.accept) begin
      front  <= front_next;
      back   <= back_next;
      count  <= count_next;
      pop_ok <= pop_ok_next;
    end
  end

  // pending status of the request in flight
  always_ff @(posedge clk) begin
    if (cmd.accept) status <= status_next;
  end

  // response register, occupancy masked to the field width
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.pop_value <= pop_ok ? $signed(rd_data) : 32'sd0;
      rsp.status    <= status;
      rsp.occupancy <= 4'(count);
    end
  end

endmodule

`default_nettype wire

/* design/double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_core
// double-ended queue in a ring store, push and pop at either end
// ----------------------------------------------------------------------------
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+---------------------------------
//  request  | req_valid  | req_stall  | req: req_type, push_value
//  response | rsp_valid  | rsp_stall  | rsp: pop_value, status, occupancy
//
//  a request is not taken while the last one loads: the accept cycle updates
//  pointers and count and issues the store access, the next cycle loads the
//  response register from the registered store read port.
//  the response register frees intake: a new request is taken while a
//  response waits, unless that response is stalled in the same cycle.
//  reset clears pointers and count; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module double_ended_queue_core #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire deq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output deq_pkg::rsp_t      rsp
);

  deq_pkg::cmd_t cmd;

  // sequencer
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // ring datapath
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  // a request beat never lands on a blocked response
  `DEQ_ASSERT_SAME(a_no_take_on_block, req_valid && !req_stall, !(rsp_valid && rsp_stall), "request taken while response blocked")

  // the response slot is empty while the next response loads
  `DEQ_ASSERT_NEXT(a_slot_free, req_valid && !req_stall, !rsp_valid && req_stall, "response slot busy during load")

  // every accepted request yields a response once its load state has passed
  `DEQ_ASSERT_SAME(a_rsp_follows, req_valid && !req_stall, ##2 rsp_valid, "no response after request")

  // refused requests carry a zero value
  `DEQ_ASSERT_SAME(a_refused_zero, rsp_valid && rsp.status != deq_pkg::ST_DONE, rsp.pop_value == 32'sd0, "refused request with nonzero value")

endmodule

`default_nettype wire

/* bench/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// Watches both channels of the double-ended queue and predicts each response
// from its own copy of the ring, pointers and count. Every accepted response
// is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_checker #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  deq_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  deq_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            checked,
  output int            full_refusals,
  output int            empty_refusals
);

  import deq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // predicted queue contents
  logic [31:0]   ring [DEPTH];
  logic [IW-1:0] head_slot;
  logic [IW-1:0] tail_slot;
  logic [CW-1:0] held;

  // responses predicted but not yet seen
  rsp_t awaited_rsp [$];

  function automatic logic [IW-1:0] slot_after(input logic [IW-1:0] s);
    return (s == IW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IW-1:0] slot_before(input logic [IW-1:0] s);
    return (s == '0) ? IW'(DEPTH - 1) : s - 1'b1;
  endfunction

  // apply one request to the predicted queue, return the response it gives
  function automatic rsp_t apply_request(input req_t r);
    rsp_t out;
    out.pop_value = '0;
    out.status    = ST_DONE;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (held == CW'(DEPTH)) begin
          out.status = ST_FULL;
          full_refusals++;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          head_slot       = slot_before(head_slot);
          ring[head_slot] = r.push_value;
          held            = held + 1'b1;
        end else begin
          ring[tail_slot] = r.push_value;
          tail_slot       = slot_after(tail_slot);
          held            = held + 1'b1;
        end
      end
      default: begin
        if (held == '0) begin
          out.status = ST_EMPTY;
          empty_refusals++;
        end else if (r.req_type == REQ_POP_FRONT) begin
          out.pop_value = ring[head_slot];
          head_slot     = slot_after(head_slot);
          held          = held - 1'b1;
        end else begin
          tail_slot     = slot_before(tail_slot);
          out.pop_value = ring[tail_slot];
          held          = held - 1'b1;
        end
      end
    endcase
    out.occupancy = 4'(held);
    return out;
  endfunction

  // print a bounded number of lines, count every mismatch
  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // responses are retired before the same-edge request is predicted
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      head_slot = '0;
      tail_slot = '0;
      held      = '0;
      awaited_rsp.delete();
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("response beat %h with nothing expected", rsp));
        end else begin
          want = awaited_rsp.pop_front();
          checked++;
          if (rsp.pop_value !== want.pop_value)
            report_mismatch($sformatf("response %0d pop_value got %h want %h",
                                      checked, rsp.pop_value, want.pop_value));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("response %0d status got %0d want %0d",
                                      checked, rsp.status, want.status));
          if (rsp.occupancy !== want.occupancy)
            report_mismatch($sformatf("response %0d occupancy got %0d want %0d",
                                      checked, rsp.occupancy, want.occupancy));
        end
      end
      if (req_valid === 1'b1 && req_stall === 1'b0)
        awaited_rsp.push_back(apply_request(req));
    end
    pending <= awaited_rsp.size();
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the double-ended queue in bursts with random gaps and
// stalls its responses on a changing pattern. A directed sequence covers
// empty and full refusals and front pointer wrap both ways; random phases then sweep
// the fill level from mostly pushes to mostly pops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import deq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEFAULT;
  localparam int          IDLE_LIMIT = 1000;
  localparam int          PHASES     = 23;
  localparam int          PHASE_LEN  = 60;

  typedef enum int {
    RX_OPEN,
    RX_SPOTTY,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int checked;
  int full_refusals;
  int empty_refusals;

  int       burst_left = 0;
  int       op_count [4];
  int       quiet_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_period = 2;
  int       rx_tick = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  deq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  // offer one request beat, opening a new burst after a gap when needed
  task automatic issue(input logic [1:0] kind, input logic [31:0] value);
    req_t item;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    item.req_type   = kind;
    item.push_value = value;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    op_count[kind]++;
  endtask

  // hold the sender off until every response has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver stall pattern, a new mode is drawn when the current run ends
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      rx_left   = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 5);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     rsp_stall <= 1'b0;
      RX_SPOTTY:   rsp_stall <= ($urandom_range(0, 99) < 30);
      RX_PERIODIC: rsp_stall <= ((rx_tick % rx_period) != 0);
      default:     rsp_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles, %0d responses outstanding",
               IDLE_LIMIT, pending);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          push_pct [7] = '{85, 50, 15, 65, 35, 95, 5};
    logic [1:0]  kind;
    logic [31:0] value;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pops on the empty queue
    issue(REQ_POP_FRONT, $urandom);
    issue(REQ_POP_BACK, $urandom);
    // fill from both ends, front wraps below slot zero
    issue(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    issue(REQ_PUSH_FRONT, 32'h8000_0000);
    issue(REQ_PUSH_BACK, 32'h0000_0000);
    issue(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    issue(REQ_PUSH_BACK, 32'h0000_0001);
    issue(REQ_PUSH_FRONT, 32'h5555_5555);
    issue(REQ_PUSH_BACK, 32'hAAAA_AAAA);
    issue(REQ_PUSH_FRONT, 32'h0000_0002);
    // pushes on the full queue
    issue(REQ_PUSH_BACK, 32'h1234_5678);
    issue(REQ_PUSH_FRONT, 32'h8765_4321);
    // drain alternating ends, then one more pop on empty
    repeat (4) begin
      issue(REQ_POP_FRONT, $urandom);
      issue(REQ_POP_BACK, $urandom);
    end
    issue(REQ_POP_FRONT, $urandom);
    // single entries popped from the opposite end
    issue(REQ_PUSH_BACK, 32'h0F0F_0F0F);
    issue(REQ_POP_FRONT, $urandom);
    issue(REQ_PUSH_FRONT, 32'hF0F0_F0F0);
    issue(REQ_POP_BACK, $urandom);

    // random phases, each biased toward pushes or pops
    for (int p = 0; p < PHASES; p++) begin
      if (p == 7 || p == 16) wait_drained();
      for (int i = 0; i < PHASE_LEN; i++) begin
        if ($urandom_range(0, 99) < push_pct[p % 7])
          kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else
          kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        case ($urandom_range(0, 9))
          0:       value = 32'h7FFF_FFFF;
          1:       value = 32'h8000_0000;
          2:       value = 32'h0000_0000;
          3:       value = 32'hFFFF_FFFF;
          default: value = $urandom;
        endcase
        issue(kind, value);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);

    $display("requests: %0d push front, %0d push back, %0d pop front, %0d pop back",
             op_count[REQ_PUSH_FRONT], op_count[REQ_PUSH_BACK],
             op_count[REQ_POP_FRONT], op_count[REQ_POP_BACK]);
    $display("responses checked: %0d, refused on full: %0d, refused on empty: %0d",
             checked, full_refusals, empty_refusals);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d responses outstanding", fail_count, pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
